@@ design/cartesian_to_cylindrical_macros.svh @@
// Assertion macros used by the checker of the cartesian to cylindrical converter.
`ifndef CARTESIAN_TO_CYLINDRICAL_MACROS_SVH
`define CARTESIAN_TO_CYLINDRICAL_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CYL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cartesian_to_cylindrical check failed");

// Next-cycle implication, checked during reset as well.
`define CYL_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cartesian_to_cylindrical check failed");

`endif

@@ design/cyl_pkg.sv @@
// Package with types, constants and the arctangent table of the converter.
`default_nettype none
package cyl_pkg;

   // Field widths of the words on the ports.
   localparam int CYL_COORD_WIDTH = 16;
   localparam int CYL_ANGLE_WIDTH = 16;

   // Internal angle accumulator: 2^31 stands for pi.
   localparam int CYL_PHASE_WIDTH = 32;

   // CORDIC datapath: coordinates are scaled up so that every step keeps full precision.
   localparam int CYL_ACC_WIDTH = 64;
   localparam int CYL_PRESCALE  = 60 - CYL_COORD_WIDTH;

   // Square-root datapath holds the sum of squares.
   localparam int CYL_SQ_WIDTH = 2 * CYL_COORD_WIDTH;

   // Default number of micro-rotations.
   localparam int CYL_ROTATION_STEPS_DEF = 16;

   // Quadrant offsets applied by the pre-rotation.
   localparam logic [CYL_PHASE_WIDTH-1:0] CYL_PHASE_QUARTER = 32'h4000_0000;
   localparam logic [CYL_PHASE_WIDTH-1:0] CYL_PHASE_MINUS_QUARTER = 32'hC000_0000;

   // Input word.
   typedef struct packed {
      logic signed [CYL_COORD_WIDTH-1:0] x_coord;
      logic signed [CYL_COORD_WIDTH-1:0] y_coord;
      logic signed [CYL_COORD_WIDTH-1:0] z_coord;
   } cyl_req_type;

   // Result word.
   typedef struct packed {
      logic        [CYL_COORD_WIDTH-1:0] radius;
      logic signed [CYL_ANGLE_WIDTH-1:0] azimuth;
      logic signed [CYL_COORD_WIDTH-1:0] height;
   } cyl_rsp_type;

   // Word that travels down the pipeline.
   typedef struct packed {
      logic signed [CYL_ACC_WIDTH-1:0]   cx;
      logic signed [CYL_ACC_WIDTH-1:0]   cy;
      logic        [CYL_PHASE_WIDTH-1:0] ang;
      logic        [CYL_SQ_WIDTH-1:0]    rem;
      logic        [CYL_SQ_WIDTH-1:0]    root;
      logic                              origin;
      logic signed [CYL_COORD_WIDTH-1:0] height;
   } cyl_pipe_type;

   // Number of iterative stages: enough for both the rotations and the root digits.
   function automatic int cyl_num_stages(input int steps);
      return (steps > CYL_COORD_WIDTH) ? steps : CYL_COORD_WIDTH;
   endfunction

   // Registers between an accepted word and its result strobe: two front layers, the
   // iterative stages and the output register.
   function automatic int cyl_latency(input int steps);
      return cyl_num_stages(steps) + 3;
   endfunction

   // atan(2^-i) with 2^31 standing for pi.
   function automatic logic [CYL_PHASE_WIDTH-1:0] cyl_atan(input logic [4:0] idx);
      logic [CYL_PHASE_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = 32'h2000_0000;
         5'd1:    val = 32'h12E4_051E;
         5'd2:    val = 32'h09FB_385B;
         5'd3:    val = 32'h0511_11D4;
         5'd4:    val = 32'h028B_0D43;
         5'd5:    val = 32'h0145_D7E1;
         5'd6:    val = 32'h00A2_F61E;
         5'd7:    val = 32'h0051_7C55;
         5'd8:    val = 32'h0028_BE53;
         5'd9:    val = 32'h0014_5F2F;
         5'd10:   val = 32'h000A_2F98;
         5'd11:   val = 32'h0005_17CC;
         5'd12:   val = 32'h0002_8BE6;
         5'd13:   val = 32'h0001_45F3;
         5'd14:   val = 32'h0000_A2FA;
         5'd15:   val = 32'h0000_517D;
         5'd16:   val = 32'h0000_28BE;
         5'd17:   val = 32'h0000_145F;
         5'd18:   val = 32'h0000_0A30;
         5'd19:   val = 32'h0000_0518;
         5'd20:   val = 32'h0000_028C;
         5'd21:   val = 32'h0000_0146;
         5'd22:   val = 32'h0000_00A3;
         5'd23:   val = 32'h0000_0051;
         5'd24:   val = 32'h0000_0029;
         5'd25:   val = 32'h0000_0014;
         5'd26:   val = 32'h0000_000A;
         5'd27:   val = 32'h0000_0005;
         5'd28:   val = 32'h0000_0003;
         5'd29:   val = 32'h0000_0001;
         5'd30:   val = 32'h0000_0001;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

@@ design/cyl_front.sv @@
// Front end: absolute values, squares, scaling and quadrant pre-rotation.
`default_nettype none
module cyl_front
   import cyl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire cyl_req_type  in_word,
   output logic              out_valid,
   output cyl_pipe_type      out_word
);

   logic                              v1_ff;
   logic [CYL_SQ_WIDTH-1:0]           sq_x_ff, sq_x_in;
   logic [CYL_SQ_WIDTH-1:0]           sq_y_ff, sq_y_in;
   logic signed [CYL_ACC_WIDTH-1:0]   cx_ff, cx_in;
   logic signed [CYL_ACC_WIDTH-1:0]   cy_ff, cy_in;
   logic [CYL_PHASE_WIDTH-1:0]        ang_ff, ang_in;
   logic                              origin_ff, origin_in;
   logic signed [CYL_COORD_WIDTH-1:0] height_ff;
   logic                              v2_ff;
   cyl_pipe_type                      word_ff, word_in;

   logic [CYL_COORD_WIDTH-1:0]        abs_x, abs_y;
   logic signed [CYL_ACC_WIDTH-1:0]   sx, sy;

   // Magnitudes, their squares, and the pre-rotation into the right half plane.
   always_comb begin
      abs_x = in_word.x_coord[CYL_COORD_WIDTH-1] ? CYL_COORD_WIDTH'(-in_word.x_coord)
                                                 : in_word.x_coord;
      abs_y = in_word.y_coord[CYL_COORD_WIDTH-1] ? CYL_COORD_WIDTH'(-in_word.y_coord)
                                                 : in_word.y_coord;
      sq_x_in = CYL_SQ_WIDTH'(abs_x) * CYL_SQ_WIDTH'(abs_x);
      sq_y_in = CYL_SQ_WIDTH'(abs_y) * CYL_SQ_WIDTH'(abs_y);
      sx = CYL_ACC_WIDTH'(in_word.x_coord) <<< CYL_PRESCALE;
      sy = CYL_ACC_WIDTH'(in_word.y_coord) <<< CYL_PRESCALE;
      cx_in  = sx;
      cy_in  = sy;
      ang_in = '0;
      if (sx < 0) begin
         if (sy >= 0) begin
            cx_in  = sy;
            cy_in  = -sx;
            ang_in = CYL_PHASE_QUARTER;
         end else begin
            cx_in  = -sy;
            cy_in  = sx;
            ang_in = CYL_PHASE_MINUS_QUARTER;
         end
      end
      origin_in = (in_word.x_coord == '0) && (in_word.y_coord == '0);
   end

   // Second layer adds the squares and seeds the root.
   always_comb begin
      word_in.cx     = cx_ff;
      word_in.cy     = cy_ff;
      word_in.ang    = ang_ff;
      word_in.rem    = sq_x_ff + sq_y_ff;
      word_in.root   = '0;
      word_in.origin = origin_ff;
      word_in.height = height_ff;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sq_x_ff   <= sq_x_in;
      sq_y_ff   <= sq_y_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      ang_ff    <= ang_in;
      origin_ff <= origin_in;
      height_ff <= in_word.z_coord;
      word_ff   <= word_in;
   end

   assign out_valid = v2_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

@@ design/cyl_stage.sv @@
// One pipeline stage: CORDIC micro-rotation, square-root digit or both.
`default_nettype none
module cyl_stage
   import cyl_pkg::*;
#(
   parameter int STAGE_INDEX    = 0,
   parameter int ROTATION_STEPS = CYL_ROTATION_STEPS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire cyl_pipe_type  in_word,
   output logic               out_valid,
   output cyl_pipe_type       out_word
);

   localparam bit DO_ROTATE = STAGE_INDEX < ROTATION_STEPS;
   localparam bit DO_ROOT   = STAGE_INDEX < CYL_COORD_WIDTH;
   localparam int ROOT_SHIFT = DO_ROOT ? 2 * (CYL_COORD_WIDTH - 1 - STAGE_INDEX) : 0;
   localparam logic [CYL_SQ_WIDTH-1:0] ROOT_BIT = CYL_SQ_WIDTH'(1) << ROOT_SHIFT;
   localparam logic [CYL_PHASE_WIDTH-1:0] STEP_ANGLE = cyl_atan(5'(STAGE_INDEX));

   logic                            valid_ff;
   cyl_pipe_type                    word_ff, word_in;
   logic signed [CYL_ACC_WIDTH-1:0] dx, dy;
   logic [CYL_SQ_WIDTH-1:0]         trial;

   always_comb begin
      word_in = in_word;
      dx      = in_word.cy >>> STAGE_INDEX;
      dy      = in_word.cx >>> STAGE_INDEX;
      trial   = in_word.root + ROOT_BIT;

      // Rotate toward the x axis, steering by the sign of y.
      if (DO_ROTATE) begin
         if (in_word.cy >= 0) begin
            word_in.cx  = in_word.cx + dx;
            word_in.cy  = in_word.cy - dy;
            word_in.ang = in_word.ang + STEP_ANGLE;
         end else begin
            word_in.cx  = in_word.cx - dx;
            word_in.cy  = in_word.cy + dy;
            word_in.ang = in_word.ang - STEP_ANGLE;
         end
      end

      // One digit of the restoring square root.
      if (DO_ROOT) begin
         if (in_word.rem >= trial) begin
            word_in.rem  = in_word.rem - trial;
            word_in.root = (in_word.root >> 1) + ROOT_BIT;
         end else begin
            word_in.root = in_word.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

@@ design/cyl_back.sv @@
// Back end: rounds radius and angle and holds the result register.
`default_nettype none
module cyl_back
   import cyl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire cyl_pipe_type  in_word,
   output logic               out_valid,
   output cyl_rsp_type        out_word
);

   localparam logic [CYL_PHASE_WIDTH-1:0] HALF_LSB =
      CYL_PHASE_WIDTH'(1) << (CYL_PHASE_WIDTH - CYL_ANGLE_WIDTH - 1);

   logic                       valid_ff;
   cyl_rsp_type                word_ff, word_in;
   logic [CYL_PHASE_WIDTH-1:0] ang_round;

   // Round the root up when the remainder exceeds it; round the angle to nearest.
   always_comb begin
      ang_round      = in_word.ang + HALF_LSB;
      word_in.radius = in_word.root[CYL_COORD_WIDTH-1:0]
                       + CYL_COORD_WIDTH'(in_word.rem > in_word.root);
      word_in.azimuth = in_word.origin ? '0
                        : ang_round[CYL_PHASE_WIDTH-1 -: CYL_ANGLE_WIDTH];
      word_in.height = in_word.height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

@@ design/cartesian_to_cylindrical.sv @@
// Cartesian to cylindrical converter: radius, azimuth and height of one point.
//
// Input: req_word carries x, y and z. A word is taken at a rising edge where start
// is high and busy is low. busy is high only during reset and the cycle after it,
// so in normal operation a new word may be issued in every cycle.
// Output: each result appears on rsp_word for one cycle with rsp_valid high, in
// issue order; the receiver must take it then, as nothing holds results back.
// Pipeline: two front layers (squares, sum and pre-rotation), one stage per
// rotation step, root digit or both, and the output register. Throughput is one
// word per cycle while busy is low, set by the fully unrolled stage chain.
// Radius is the exact square root rounded to nearest; azimuth is a binary angle
// with 32768 standing for pi, 0 at the origin.
// Reset clears every valid bit, so words in flight are dropped and no strobe
// follows until new words are issued.
`default_nettype none
module cartesian_to_cylindrical
   import cyl_pkg::*;
#(
   parameter int ROTATION_STEPS = CYL_ROTATION_STEPS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire cyl_req_type  req_word,
   output logic              rsp_valid,
   output cyl_rsp_type       rsp_word
);

   localparam int NUM_STAGES = cyl_num_stages(ROTATION_STEPS);

   logic         busy_ff;
   logic         accept;
   logic         stage_valid [NUM_STAGES+1];
   cyl_pipe_type stage_word  [NUM_STAGES+1];

   // Hold off new words around reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = reset | busy_ff;
   assign accept = start & ~busy;

   cyl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (req_word),
      .out_valid (stage_valid[0]),
      .out_word  (stage_word[0])
   );

   // Unrolled rotation and root stages.
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      cyl_stage #(
         .STAGE_INDEX    (i),
         .ROTATION_STEPS (ROTATION_STEPS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_word   (stage_word[i]),
         .out_valid (stage_valid[i+1]),
         .out_word  (stage_word[i+1])
      );
   end

   cyl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[NUM_STAGES]),
      .in_word   (stage_word[NUM_STAGES]),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule
`default_nettype wire

@@ design/cyl_checker.sv @@
// Port-level checker for the cartesian to cylindrical converter, with its bind.
`default_nettype none
`include "cartesian_to_cylindrical_macros.svh"
module cyl_checker
   import cyl_pkg::*;
#(
   parameter int ROTATION_STEPS = CYL_ROTATION_STEPS_DEF
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire cyl_req_type  req_word,
   input wire logic         rsp_valid,
   input wire cyl_rsp_type  rsp_word
);

   localparam int LATENCY = cyl_latency(ROTATION_STEPS);

   // Reset empties the pipeline.
   `CYL_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid)

   // Every strobe comes from a word that was accepted, found back through cyl_latency.
   `CYL_ASSERT_SAME(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, LATENCY))

   // Height is the z of that same word.
   `CYL_ASSERT_SAME(a_height_kept, clock, reset, rsp_valid,
      rsp_word.height == $past(req_word.z_coord, LATENCY))

   // A zero radius only occurs at the origin, whose angle is zero.
   `CYL_ASSERT_SAME(a_origin_angle, clock, reset, rsp_valid && rsp_word.radius == '0,
      rsp_word.azimuth == '0)

endmodule

bind cartesian_to_cylindrical cyl_checker #(.ROTATION_STEPS(ROTATION_STEPS)) u_cyl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
`default_nettype wire

@@ tb/cartesian_to_cylindrical_test.sv @@
// Self-checking testbench of the cartesian to cylindrical converter.
module cartesian_to_cylindrical_test;
   import cyl_pkg::*;

   localparam int STEP_COUNT   = CYL_ROTATION_STEPS_DEF;
   localparam int DRAIN_CYCLES = cyl_latency(STEP_COUNT) + 8;
   localparam int IDLE_LIMIT   = 600;
   localparam int RANDOM_ITEMS = 480;
   localparam int STEADY_TAIL  = 80;

   // Arctangent of 2^-i, with 2^31 standing for pi.
   localparam logic [CYL_PHASE_WIDTH-1:0] ARCTAN_STEP [0:15] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   cyl_req_type req_word = '0;
   logic        rsp_valid;
   cyl_rsp_type rsp_word;

   cyl_req_type pending_points[$];
   cyl_rsp_type expected_results[$];
   int          gap_left = 0;
   int          points_accepted = 0;
   int          results_checked = 0;
   int          error_count = 0;
   int          idle_cycles = 0;

   cartesian_to_cylindrical i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always #2 clock = ~clock;

   // Radius, azimuth and height that one point must convert to.
   function automatic cyl_rsp_type predict_cylindrical(input cyl_req_type pt);
      cyl_rsp_type                res;
      longint signed              xs, ys, cx, cy, t, dx, dy;
      longint unsigned            n, root, rest, bitv;
      logic [CYL_PHASE_WIDTH-1:0] ang, rounded;
      xs = longint'($signed(pt.x_coord));
      ys = longint'($signed(pt.y_coord));

      // Exact integer square root of the sum of squares, then round to nearest.
      n = longint'(xs * xs + ys * ys);
      rest = n;
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rest >= root + bitv) begin
            rest = rest - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      if (n - root * root > root) root = root + 1;
      res.radius = root[CYL_COORD_WIDTH-1:0];

      // Vectoring CORDIC on the scaled point; the origin gives angle zero.
      res.azimuth = '0;
      if (xs != 0 || ys != 0) begin
         cx = xs <<< CYL_PRESCALE;
         cy = ys <<< CYL_PRESCALE;
         ang = '0;
         // Points left of the y axis are first turned by a quarter circle.
         if (cx < 0) begin
            t = cx;
            if (cy >= 0) begin
               cx = cy;
               cy = -t;
               ang = CYL_PHASE_QUARTER;
            end else begin
               cx = -cy;
               cy = t;
               ang = CYL_PHASE_MINUS_QUARTER;
            end
         end
         for (int k = 0; k < STEP_COUNT; k++) begin
            dx = cy >>> k;
            dy = cx >>> k;
            if (cy >= 0) begin
               cx = cx + dx;
               cy = cy - dy;
               ang = ang + ARCTAN_STEP[k];
            end else begin
               cx = cx - dx;
               cy = cy + dy;
               ang = ang - ARCTAN_STEP[k];
            end
         end
         rounded = ang + 32'h0000_8000;
         res.azimuth = rounded[31:16];
      end
      res.height = pt.z_coord;
      return res;
   endfunction

   task automatic add_point(input int x, input int y, input int z);
      cyl_req_type pt;
      pt.x_coord = 16'(x);
      pt.y_coord = 16'(y);
      pt.z_coord = 16'(z);
      pending_points.push_back(pt);
   endtask

   // Driver: issues pending words, holds a word until it is taken, idles in bursts.
   always @(posedge clock) begin : driver
      cyl_req_type next_word;
      logic        next_start;
      next_word = req_word;
      next_start = start;
      if (reset) begin
         next_start = 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(predict_cylindrical(req_word));
            points_accepted++;
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_points.size() > 0) begin
               if (pending_points.size() > STEADY_TAIL && $urandom_range(0, 7) == 0) begin
                  // This cycle opens a burst of idle cycles of random length.
                  gap_left = $urandom_range(0, 13);
               end else begin
                  next_word = pending_points.pop_front();
                  next_start = 1'b1;
               end
            end
         end
      end
      start <= next_start;
      req_word <= next_word;
   end

   // Monitor: every strobed result word is compared with the oldest prediction.
   always @(posedge clock) begin : monitor
      cyl_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result word, expected none, actual %h", $time,
                     rsp_word);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_word.radius !== want.radius) begin
               error_count++;
               $display("%0t: radius mismatch, expected %0d, actual %0d", $time,
                        want.radius, rsp_word.radius);
            end
            if (rsp_word.azimuth !== want.azimuth) begin
               error_count++;
               $display("%0t: azimuth mismatch, expected %0d, actual %0d", $time,
                        $signed(want.azimuth), $signed(rsp_word.azimuth));
            end
            if (rsp_word.height !== want.height) begin
               error_count++;
               $display("%0t: height mismatch, expected %0d, actual %0d", $time,
                        $signed(want.height), $signed(rsp_word.height));
            end
         end
      end
   end

   // Watchdog: cycles since the last accepted word or strobed result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : stimulus
      int   corner_vals[6] = '{-32768, -32767, -1, 0, 1, 32767};
      int   x, y, z;
      logic timed_out;

      // Directed points: origin, axes, corners, the wrap at pi and small radii.
      add_point(0, 0, 0);
      add_point(0, 0, 32767);
      add_point(32767, 0, -32768);
      add_point(-32768, 0, 1);
      add_point(-1, 0, -1);
      add_point(0, 32767, 0);
      add_point(0, -32768, 0);
      add_point(32767, 32767, 12345);
      add_point(-32768, -32768, -12345);
      add_point(-32768, 32767, 0);
      add_point(32767, -32768, 0);
      add_point(-32768, 1, 0);
      add_point(-32768, -1, 0);
      add_point(1, 0, 0);
      add_point(0, 1, 0);
      add_point(1, 1, 0);
      add_point(-1, 1, 0);
      add_point(1, -1, 0);
      add_point(-1, -1, 0);
      add_point(3, 4, 0);
      add_point(-5, 0, 0);
      add_point(-32767, 0, 0);

      // Random points of several shapes; z always spans its whole range.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         z = $urandom;
         case ($urandom_range(0, 5))
            0, 1: begin
               x = $urandom;
               y = $urandom;
            end
            2: begin
               x = int'($urandom_range(0, 40)) - 20;
               y = int'($urandom_range(0, 40)) - 20;
            end
            3: begin
               x = $urandom;
               y = int'($urandom_range(0, 2)) - 1;
               if ($urandom_range(0, 1) == 1) begin
                  z = x;
                  x = y;
                  y = z;
                  z = $urandom;
               end
            end
            4: begin
               x = corner_vals[$urandom_range(0, 5)];
               y = corner_vals[$urandom_range(0, 5)];
            end
            default: begin
               x = $urandom_range(0, 32767);
               y = ($urandom_range(0, 1) == 1) ? -x : x;
               if ($urandom_range(0, 1) == 1) x = -x;
            end
         endcase
         add_point(x, y, z);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Run until every word is issued and answered, or the watchdog expires.
      timed_out = 1'b0;
      while ((pending_points.size() > 0 || start || expected_results.size() > 0)
             && !timed_out) begin
         @(negedge clock);
         if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
      end
      if (timed_out)
         $display("%0t: watchdog expired with %0d results outstanding", $time,
                  expected_results.size());
      else
         repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d predicted results never arrived", $time,
                  expected_results.size());
      end

      $display("Converted %0d points with %0d results checked, covering origin, axes,",
               points_accepted, results_checked);
      $display("quadrant corners, the wrap at pi and random points; %0d errors.",
               error_count);
      if (!timed_out && error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/cyl_pkg.sv
design/cyl_front.sv
design/cyl_stage.sv
design/cyl_back.sv
design/cartesian_to_cylindrical.sv
design/cyl_checker.sv
tb/cartesian_to_cylindrical_test.sv
